// ===== rtl/core/ismu_pkg.sv =====
// shared types and constants of the ising metropolis spin update block
package ismu_pkg;

    localparam int ROW_W      = 6;
    localparam int DRAW_W     = 16;
    localparam int SIDE_W     = 7;
    localparam int LEVEL_W    = 17;
    localparam int LEVEL_FRAC = 16;
    localparam int UP_W       = 13;
    localparam int MAG_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    // columns counted per cycle during a recount
    localparam int CHUNK      = 8;

    localparam logic [SIDE_W-1:0]  SIDE_RESET  = 7'd64;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_M4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_M2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_P4 = 3'd4;

    localparam logic [1:0] LVL_M4 = 2'd0;
    localparam logic [1:0] LVL_M2 = 2'd1;
    localparam logic [1:0] LVL_P2 = 2'd2;
    localparam logic [1:0] LVL_P4 = 2'd3;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef struct packed {
        logic accept;
        logic read_down;
        logic exec;
        logic clr_write;
        logic cnt_init;
        logic cnt_read;
        logic cnt_load;
        logic cnt_add;
    } cmd_t;

    typedef struct packed {
        logic side_wr;
        logic clr_last;
        logic col_last;
        logic row_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/core/ismu_ctrl.sv =====
// sequencer for clear pass, spin items and up-spin recount
module ismu_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ismu_pkg::sts_t sts,
    output ismu_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ2,
        ST_EXEC,
        ST_CNT_READ,
        ST_CNT_LOAD,
        ST_CNT_ADD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pending_reg;
    logic   pending_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    cmd.cnt_init = 1'b1;
                    state_next   = ST_CNT_READ;
                end
                else
                begin
                    s_tready = !sts.side_wr;
                    if (s_tvalid && !sts.side_wr)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_READ2;
                    end
                end
            end
            ST_READ2:
            begin
                cmd.read_down = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CNT_READ:
            begin
                if (pending_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_read = 1'b1;
                    state_next   = ST_CNT_LOAD;
                end
            end
            ST_CNT_LOAD:
            begin
                if (pending_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_load = 1'b1;
                    state_next   = ST_CNT_ADD;
                end
            end
            ST_CNT_ADD:
            begin
                if (pending_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.cnt_add = 1'b1;
                    if (sts.col_last)
                    begin
                        state_next = sts.row_last ? ST_IDLE : ST_CNT_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a new side write restarts any recount in progress
    always_comb
    begin
        if (sts.side_wr)
        begin
            pending_next = 1'b1;
        end
        else if (cmd.cnt_init)
        begin
            pending_next = 1'b0;
        end
        else
        begin
            pending_next = pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !sts.out_busy)
        else $error("commit issued while result register is still full");

    a_side_block: assert property (@(posedge clk) disable iff (!rst_n)
        sts.side_wr |=> !s_tready)
        else $error("word accepted right after a side write");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 (state_reg == ST_EXEC))
        else $error("accepted word did not reach the commit step");

endmodule

// ===== rtl/core/ismu_datapath.sv =====
// lattice store, configuration registers, metropolis test and result register
module ismu_datapath
#(
    parameter int MAX_SIDE  = 64,
    parameter int DRAW_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ismu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ismu_pkg::LEVEL_W-1:0]         cfg_wdata,
    input  logic                                 in_action,
    input  logic [ismu_pkg::ROW_W-1:0]           in_row,
    input  logic [ismu_pkg::ROW_W-1:0]           in_col,
    input  logic                                 in_spin,
    input  logic [ismu_pkg::DRAW_W-1:0]          in_draw,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic                                 out_flipped,
    output logic                                 out_spin_after,
    output logic signed [ismu_pkg::MAG_W-1:0]    out_magnetization,
    output logic                                 out_bad_site,
    input  ismu_pkg::cmd_t                       cmd,
    output ismu_pkg::sts_t                       sts
);

    localparam int RW     = $clog2(MAX_SIDE);
    localparam int XW_RAW = $clog2(MAX_SIDE + ismu_pkg::CHUNK + 1);
    localparam int XW     = (XW_RAW > ismu_pkg::SIDE_W) ? XW_RAW : ismu_pkg::SIDE_W;
    localparam int SH_W   = MAX_SIDE + ismu_pkg::CHUNK;
    localparam int CS_W   = $clog2(ismu_pkg::CHUNK + 1);
    localparam int DB_USE = (DRAW_BITS < ismu_pkg::DRAW_W) ? DRAW_BITS : ismu_pkg::DRAW_W;
    localparam int CMP_W  = ismu_pkg::LEVEL_W +
                            ((DRAW_BITS > ismu_pkg::LEVEL_FRAC) ? DRAW_BITS
                                                                : ismu_pkg::LEVEL_FRAC);
    localparam logic [ismu_pkg::DRAW_W-1:0] DRAW_MASK =
        ismu_pkg::DRAW_W'((33'd1 << DB_USE) - 33'd1);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_SIDE);
    localparam logic [RW-1:0] LAST_ROW = RW'(MAX_SIDE - 1);

    // configuration
    logic [ismu_pkg::SIDE_W-1:0]  side_raw_reg;
    logic [ismu_pkg::LEVEL_W-1:0] level_reg [4];
    logic [XW-1:0]                side_x;
    logic [XW-1:0]                s_use;
    logic [2*XW-1:0]              sq_full;
    logic [ismu_pkg::MAG_W-1:0]   sq_reg;

    // lattice store, one row per word
    logic [MAX_SIDE-1:0] lattice_mem [MAX_SIDE];
    logic                mem_we;
    logic [RW-1:0]       mem_waddr;
    logic [MAX_SIDE-1:0] mem_wdata;
    logic                rd_a_en;
    logic                rd_b_en;
    logic [RW-1:0]       rd_a_addr;
    logic [RW-1:0]       rd_b_addr;
    logic [MAX_SIDE-1:0] rd_a_reg;
    logic [MAX_SIDE-1:0] rd_b_reg;
    logic [MAX_SIDE-1:0] row_up_reg;

    // item
    logic                         item_action_reg;
    logic [ismu_pkg::ROW_W-1:0]   item_row_reg;
    logic [ismu_pkg::ROW_W-1:0]   item_col_reg;
    logic                         item_spin_reg;
    logic [ismu_pkg::DRAW_W-1:0]  item_draw_reg;

    logic [XW-1:0] in_row_x;
    logic [XW-1:0] row_x;
    logic [XW-1:0] col_x;
    logic [XW-1:0] ru_x;
    logic [XW-1:0] rd_x;
    logic [XW-1:0] cl_x;
    logic [XW-1:0] cr_x;

    logic                          bad;
    logic                          cur;
    logic [2:0]                    ups;
    logic [1:0]                    lvl_idx;
    logic [ismu_pkg::LEVEL_W-1:0]  lvl;
    logic [ismu_pkg::DRAW_W-1:0]   draw_eff;
    logic [CMP_W-1:0]              draw_sh;
    logic [CMP_W-1:0]              lvl_sh;
    logic                          flip;
    logic                          new_bit;
    logic                          changed;
    logic [MAX_SIDE-1:0]           row_new;
    logic [ismu_pkg::UP_W-1:0]     up_count_reg;
    logic [ismu_pkg::UP_W-1:0]     up_exec;
    logic [ismu_pkg::MAG_W-1:0]    mag_w;

    // clear pass and recount
    logic [RW-1:0]             clr_cnt_reg;
    logic [RW-1:0]             cnt_row_reg;
    logic [XW-1:0]             cnt_col_reg;
    logic [ismu_pkg::UP_W-1:0] acc_reg;
    logic [ismu_pkg::UP_W-1:0] acc_next;
    logic [SH_W-1:0]           shift_reg;
    logic [CS_W-1:0]           chunk_sum;

    logic                       m_tvalid_reg;
    logic                       out_flipped_reg;
    logic                       out_spin_reg;
    logic [ismu_pkg::MAG_W-1:0] out_mag_reg;
    logic                       out_bad_reg;

    // side in use, clamped to the supported range
    always_comb
    begin
        side_x = XW'(side_raw_reg);
        if (side_x < XW'(2))
        begin
            s_use = XW'(2);
        end
        else if (side_x > MAX_X)
        begin
            s_use = MAX_X;
        end
        else
        begin
            s_use = side_x;
        end
    end

    assign sq_full = {{XW{1'b0}}, s_use} * {{XW{1'b0}}, s_use};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_raw_reg <= ismu_pkg::SIDE_RESET;
            for (int i = 0; i < 4; i++)
            begin
                level_reg[i] <= ismu_pkg::LEVEL_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ismu_pkg::CFG_SIDE:   side_raw_reg <= cfg_wdata[ismu_pkg::SIDE_W-1:0];
                ismu_pkg::CFG_LVL_M4: level_reg[ismu_pkg::LVL_M4] <= cfg_wdata;
                ismu_pkg::CFG_LVL_M2: level_reg[ismu_pkg::LVL_M2] <= cfg_wdata;
                ismu_pkg::CFG_LVL_P2: level_reg[ismu_pkg::LVL_P2] <= cfg_wdata;
                ismu_pkg::CFG_LVL_P4: level_reg[ismu_pkg::LVL_P4] <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // neighbour rows and columns with periodic wrap
    assign in_row_x = XW'(in_row);
    assign row_x    = XW'(item_row_reg);
    assign col_x    = XW'(item_col_reg);
    assign ru_x     = (in_row_x == '0) ? s_use - XW'(1) : in_row_x - XW'(1);
    assign rd_x     = (row_x + XW'(1) == s_use) ? '0 : row_x + XW'(1);
    assign cl_x     = (col_x == '0) ? s_use - XW'(1) : col_x - XW'(1);
    assign cr_x     = (col_x + XW'(1) == s_use) ? '0 : col_x + XW'(1);

    assign rd_a_en   = cmd.accept | cmd.cnt_read;
    assign rd_b_en   = cmd.accept | cmd.read_down;
    assign rd_a_addr = cmd.cnt_read ? cnt_row_reg : in_row_x[RW-1:0];
    assign rd_b_addr = cmd.accept ? ru_x[RW-1:0] : rd_x[RW-1:0];

    // metropolis decision on the committed item
    assign bad = (row_x >= s_use) || (col_x >= s_use);
    assign cur = rd_a_reg[col_x[RW-1:0]];
    assign ups = {2'b00, rd_a_reg[cl_x[RW-1:0]]} + {2'b00, rd_a_reg[cr_x[RW-1:0]]}
               + {2'b00, row_up_reg[col_x[RW-1:0]]} + {2'b00, rd_b_reg[col_x[RW-1:0]]};

    always_comb
    begin
        case (ups)
            3'd0:    lvl_idx = cur ? ismu_pkg::LVL_M4 : ismu_pkg::LVL_P4;
            3'd1:    lvl_idx = cur ? ismu_pkg::LVL_M2 : ismu_pkg::LVL_P2;
            3'd3:    lvl_idx = cur ? ismu_pkg::LVL_P2 : ismu_pkg::LVL_M2;
            default: lvl_idx = cur ? ismu_pkg::LVL_P4 : ismu_pkg::LVL_M4;
        endcase
    end

    assign lvl      = level_reg[lvl_idx];
    assign draw_eff = item_draw_reg & DRAW_MASK;
    assign draw_sh  = CMP_W'(draw_eff) << ismu_pkg::LEVEL_FRAC;
    assign lvl_sh   = CMP_W'(lvl) << DRAW_BITS;
    // two up neighbours out of four means no energy change
    assign flip     = (item_action_reg == ismu_pkg::ACT_UPDATE) &&
                      ((ups == 3'd2) || (draw_sh < lvl_sh));
    assign new_bit  = (item_action_reg == ismu_pkg::ACT_LOAD) ? item_spin_reg : (cur ^ flip);
    assign changed  = !bad && (new_bit != cur);

    always_comb
    begin
        row_new = rd_a_reg;
        row_new[col_x[RW-1:0]] = new_bit;
    end

    always_comb
    begin
        if (changed)
        begin
            up_exec = new_bit ? up_count_reg + ismu_pkg::UP_W'(1)
                              : up_count_reg - ismu_pkg::UP_W'(1);
        end
        else
        begin
            up_exec = up_count_reg;
        end
    end

    assign mag_w = {up_exec, 1'b0} - sq_reg;

    assign mem_we    = cmd.clr_write | (cmd.exec & !bad);
    assign mem_waddr = cmd.clr_write ? clr_cnt_reg : row_x[RW-1:0];
    assign mem_wdata = cmd.clr_write ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= lattice_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= lattice_mem[rd_b_addr];
        end
    end

    // masked popcount of the next chunk of the row
    always_comb
    begin
        chunk_sum = '0;
        for (int j = 0; j < ismu_pkg::CHUNK; j++)
        begin
            if (shift_reg[j] && (cnt_col_reg + XW'(j) < s_use))
            begin
                chunk_sum = chunk_sum + CS_W'(1);
            end
        end
    end

    assign acc_next = acc_reg + ismu_pkg::UP_W'(chunk_sum);

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_full[ismu_pkg::MAG_W-1:0];
        if (cmd.accept)
        begin
            item_action_reg <= in_action;
            item_row_reg    <= in_row;
            item_col_reg    <= in_col;
            item_spin_reg   <= in_spin;
            item_draw_reg   <= in_draw;
        end
        if (cmd.read_down)
        begin
            row_up_reg <= rd_b_reg;
        end
        if (cmd.cnt_load)
        begin
            shift_reg <= SH_W'(rd_a_reg);
        end
        else if (cmd.cnt_add)
        begin
            shift_reg <= shift_reg >> ismu_pkg::CHUNK;
        end
        if (cmd.exec)
        begin
            out_flipped_reg <= !bad && flip;
            out_spin_reg    <= !bad && new_bit;
            out_mag_reg     <= mag_w;
            out_bad_reg     <= bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            cnt_row_reg  <= '0;
            cnt_col_reg  <= '0;
            acc_reg      <= '0;
            up_count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + RW'(1);
            end
            if (cmd.cnt_init)
            begin
                cnt_row_reg <= '0;
                acc_reg     <= '0;
            end
            if (cmd.cnt_load)
            begin
                cnt_col_reg <= '0;
            end
            if (cmd.cnt_add)
            begin
                acc_reg     <= acc_next;
                cnt_col_reg <= cnt_col_reg + XW'(ismu_pkg::CHUNK);
                if (sts.col_last)
                begin
                    cnt_row_reg <= cnt_row_reg + RW'(1);
                end
            end
            if (cmd.cnt_add && sts.col_last && sts.row_last)
            begin
                up_count_reg <= acc_next;
            end
            else if (cmd.exec)
            begin
                up_count_reg <= up_exec;
            end
            if (cmd.exec)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.side_wr  = cfg_wr_en && (cfg_index == ismu_pkg::CFG_SIDE);
    assign sts.clr_last = (clr_cnt_reg == LAST_ROW);
    assign sts.col_last = (cnt_col_reg + XW'(ismu_pkg::CHUNK) >= s_use);
    assign sts.row_last = (XW'(cnt_row_reg) + XW'(1) == s_use);
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid          = m_tvalid_reg;
    assign out_flipped       = out_flipped_reg;
    assign out_spin_after    = out_spin_reg;
    assign out_magnetization = out_mag_reg;
    assign out_bad_site      = out_bad_reg;

endmodule

// ===== rtl/core/ising_metropolis_spin_update_top.sv =====
// top level of the ising metropolis spin update block
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata, s_tuser = action
// m        out  m_tvalid/m_tready  m_tdata, m_tuser = bad_site
// cfg      in   cfg_wr_en          cfg_index, cfg_wdata
//
// every word is handled in order: rows r and r-1 are read, then row r+1, then the
// decision is made and row r is written back; one word is in work at a time.
// a result waiting in the output register stalls only the write-back step.
// after reset the store is cleared one row a cycle, all MAX_SIDE rows, input not ready.
// a side write starts a recount of up spins; the input is not ready until it ends.
module ising_metropolis_spin_update_top
#(
    parameter int MAX_SIDE  = 64,
    parameter int DRAW_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // row[5:0], col[11:6], spin_value[12], random_draw[28:13], zero[31:29]
    input  logic [ismu_pkg::IN_DATA_W-1:0]       s_tdata,
    // action
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // flipped[0], spin_after[1], magnetization[15:2]
    output logic [ismu_pkg::OUT_DATA_W-1:0]      m_tdata,
    // bad_site
    output logic                                 m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [ismu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ismu_pkg::LEVEL_W-1:0]         cfg_wdata
);

    ismu_pkg::cmd_t cmd;
    ismu_pkg::sts_t sts;

    logic [ismu_pkg::ROW_W-1:0]        in_row;
    logic [ismu_pkg::ROW_W-1:0]        in_col;
    logic                              in_spin;
    logic [ismu_pkg::DRAW_W-1:0]       in_draw;
    logic                              out_flipped;
    logic                              out_spin_after;
    logic signed [ismu_pkg::MAG_W-1:0] out_magnetization;

    assign in_row  = s_tdata[5:0];
    assign in_col  = s_tdata[11:6];
    assign in_spin = s_tdata[12];
    assign in_draw = s_tdata[28:13];

    assign m_tdata = {out_magnetization, out_spin_after, out_flipped};

    ismu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ismu_datapath
    #(
        .MAX_SIDE  (MAX_SIDE),
        .DRAW_BITS (DRAW_BITS)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_action         (s_tuser),
        .in_row            (in_row),
        .in_col            (in_col),
        .in_spin           (in_spin),
        .in_draw           (in_draw),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_flipped       (out_flipped),
        .out_spin_after    (out_spin_after),
        .out_magnetization (out_magnetization),
        .out_bad_site      (m_tuser),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule
